// File: rtl/core/mtxq_pkg.sv
// Shared constants, types and helpers of the mutex table with FIFO wait queues.
`default_nettype none
package mtxq_pkg;

  localparam int MUTEXES = 16;
  localparam int WAITERS = 8;

  // Fixed transaction field widths
  localparam int ID_W  = 4;
  localparam int REQ_W = 16;
  localparam int ST_W  = 3;
  localparam int KIND_W = 2;

  // Derived storage widths
  localparam int MID_W  = (MUTEXES > 1) ? $clog2(MUTEXES) : 1;
  localparam int CNT_W  = $clog2(MUTEXES + 1);
  localparam int HEAD_W = (WAITERS > 1) ? $clog2(WAITERS) : 1;
  localparam int FILL_W = $clog2(WAITERS + 1);
  localparam int SUM_W  = FILL_W + 1;
  localparam int SLOTS  = MUTEXES * WAITERS;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CMP_W  = (ID_W > CNT_W) ? ID_W : CNT_W;

  typedef enum logic [KIND_W-1:0] {
    K_CREATE  = 2'd0,
    K_DESTROY = 2'd1,
    K_LOCK    = 2'd2,
    K_UNLOCK  = 2'd3
  } kind_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_INVALID = 3'd2,
    ST_BUSY    = 3'd3,
    ST_HELD    = 3'd4,
    ST_SUSPEND = 3'd5,
    ST_NOLOCK  = 3'd6
  } status_t;

  // Per-mutex table entry
  typedef struct packed {
    logic              active;
    logic              locked;
    logic [HEAD_W-1:0] head;
    logic [FILL_W-1:0] fill;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  // Waiter RAM address of queue position pos of mutex id
  function automatic logic [SLOT_W-1:0] slot_of(input logic [MID_W-1:0] id,
                                                input logic [HEAD_W-1:0] pos);
    slot_of = SLOT_W'(id) * SLOT_W'(WAITERS) + SLOT_W'(pos);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/mtxq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mtxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mutex_table_with_fifo_waiters.sv
// Top level: mutex table with per-mutex FIFO wait queues held in RAM.
// Sequence: the table entry is read, then the queue head, the outcome is decided and
//   written back through both RAMs, an unlock that hands the lock to a waiter reads the
//   new queue head in S_WAKE, and S_OUT loads the output register, waiting on out_stall.
// One transaction at a time: the next is accepted only after S_OUT has delivered the last.
// Reset: clears the id counter, sequencer and output valid; no clearing
//   pass, since create initializes a table entry before it can be used.
`default_nettype none
module mutex_table_with_fifo_waiters (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [mtxq_pkg::KIND_W-1:0] kind,
  input  wire logic [mtxq_pkg::ID_W-1:0]   mutex_id,
  input  wire logic [mtxq_pkg::REQ_W-1:0]  requester,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [mtxq_pkg::ST_W-1:0]      status,
  output logic [mtxq_pkg::ID_W-1:0]      new_id,
  output logic                           wake_valid,
  output logic [mtxq_pkg::REQ_W-1:0]     wake_requester
);
  import mtxq_pkg::*;

  // Sequencer: accept, table read, queue head read, optional wake read, deliver
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_META = 5'b00010,
    S_HEAD = 5'b00100,
    S_WAKE = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state;

  // Captured transaction
  kind_t             kind_q;
  logic [ID_W-1:0]   id_q;
  logic [REQ_W-1:0]  req_q;
  logic [MID_W-1:0]  mid;

  // Id allocator: ids are handed out in order and never reused
  logic [CNT_W-1:0]  used_count;

  // Table RAM (one entry per mutex) and waiter RAM (WAITERS slots per mutex)
  logic              meta_re;
  logic              meta_we;
  logic [MID_W-1:0]  meta_waddr;
  meta_t             meta_wdata;
  logic [META_W-1:0] meta_rbits;
  meta_t             meta_rd;

  logic              wt_re;
  logic [SLOT_W-1:0] wt_raddr;
  logic              wt_we;
  logic [SLOT_W-1:0] wt_waddr;
  logic [REQ_W-1:0]  wt_rd;

  // Result staging
  status_t           hd_status;
  logic [ID_W-1:0]   hd_new_id;
  logic              hd_wake;
  logic              cnt_inc;
  status_t           res_status;
  logic [ID_W-1:0]   res_new_id;
  logic              res_wake;
  logic [REQ_W-1:0]  res_wreq;

  // Queue position arithmetic
  logic [HEAD_W-1:0] head_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [HEAD_W-1:0] tail_pos;
  logic              usable;
  logic              table_full;
  logic              out_free;

  assign mid     = MID_W'(id_q);
  assign meta_rd = meta_t'(meta_rbits);

  mtxq_ram #(.WIDTH(META_W), .DEPTH(MUTEXES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (MID_W'(mutex_id)),
    .rdata (meta_rbits)
  );

  mtxq_ram #(.WIDTH(REQ_W), .DEPTH(SLOTS)) u_waiter_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (req_q),
    .re    (wt_re),
    .raddr (wt_raddr),
    .rdata (wt_rd)
  );

  // Single item in flight: the next one is taken only when the last is delivered
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign meta_re  = (state == S_IDLE) && in_valid;

  assign table_full = (used_count >= CNT_W'(MUTEXES));
  assign usable     = (CMP_W'(id_q) < CMP_W'(used_count)) && meta_rd.active;

  // head + 1 and head + fill, both wrapped into [0, WAITERS)
  assign head_inc = (meta_rd.head == HEAD_W'(WAITERS - 1)) ? '0 : meta_rd.head + 1'b1;
  assign tail_sum = SUM_W'(meta_rd.head) + SUM_W'(meta_rd.fill);
  assign tail_pos = (tail_sum >= SUM_W'(WAITERS)) ? HEAD_W'(tail_sum - SUM_W'(WAITERS))
                                                   : HEAD_W'(tail_sum);

  // Decide the outcome once the table entry and the queue head are both in hand
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = mid;
    meta_wdata = meta_rd;
    wt_we      = 1'b0;
    wt_waddr   = slot_of(mid, tail_pos);
    wt_re      = 1'b0;
    wt_raddr   = slot_of(mid, meta_rd.head);
    hd_status  = ST_OK;
    hd_new_id  = '0;
    hd_wake    = 1'b0;
    cnt_inc    = 1'b0;

    if (state == S_META) begin
      wt_re = 1'b1;
    end

    if (state == S_HEAD) begin
      if (kind_q == K_CREATE) begin
        if (table_full) begin
          hd_status = ST_NOSPACE;
        end else begin
          meta_we    = 1'b1;
          meta_waddr = MID_W'(used_count);
          meta_wdata = '{active: 1'b1, locked: 1'b0, head: '0, fill: '0};
          hd_new_id  = ID_W'(used_count);
          cnt_inc    = 1'b1;
        end
      end else if (!usable) begin
        hd_status = ST_INVALID;
      end else begin
        case (kind_q)
          K_DESTROY: begin
            if (meta_rd.locked) begin
              hd_status = ST_BUSY;
            end else begin
              meta_we           = 1'b1;
              meta_wdata.active = 1'b0;
            end
          end
          K_LOCK: begin
            meta_we           = 1'b1;
            meta_wdata.locked = 1'b1;
            if (meta_rd.fill != '0 && wt_rd == req_q) begin
              hd_status = ST_HELD;
            end else if (meta_rd.fill >= FILL_W'(WAITERS)) begin
              hd_status = ST_NOSPACE;
            end else begin
              wt_we           = 1'b1;
              meta_wdata.fill = meta_rd.fill + 1'b1;
              // an empty queue makes the requester the owner at once
              hd_status       = (meta_rd.fill == '0) ? ST_OK : ST_SUSPEND;
            end
          end
          default: begin
            if (!meta_rd.locked || meta_rd.fill == '0 || wt_rd != req_q) begin
              hd_status = ST_NOLOCK;
            end else begin
              meta_we           = 1'b1;
              meta_wdata.head   = head_inc;
              meta_wdata.fill   = meta_rd.fill - 1'b1;
              if (meta_rd.fill == FILL_W'(1)) begin
                meta_wdata.locked = 1'b0;
              end else begin
                // fetch the next waiter, which now owns the lock
                hd_wake  = 1'b1;
                wt_re    = 1'b1;
                wt_raddr = slot_of(mid, head_inc);
              end
            end
          end
        endcase
      end
    end
  end

  // Sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_META;
          end
        end
        S_META: begin
          state <= S_HEAD;
        end
        S_HEAD: begin
          if (cnt_inc) begin
            used_count <= used_count + 1'b1;
          end
          state <= hd_wake ? S_WAKE : S_OUT;
        end
        S_WAKE: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      kind_q <= kind_t'(kind);
      id_q   <= mutex_id;
      req_q  <= requester;
    end
    if (state == S_HEAD) begin
      res_status <= hd_status;
      res_new_id <= hd_new_id;
      res_wake   <= 1'b0;
      res_wreq   <= '0;
    end
    if (state == S_WAKE) begin
      res_wake <= 1'b1;
      res_wreq <= wt_rd;
    end
    if (state == S_OUT && out_free) begin
      status         <= res_status;
      new_id         <= res_new_id;
      wake_valid     <= res_wake;
      wake_requester <= res_wreq;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CNT_W'(MUTEXES))
    else $error("id counter beyond table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(used_count)) |-> used_count == $past(used_count) + 1'b1)
    else $error("id counter moved by other than one");

  a_wake_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wake_valid) |-> status == ST_OK)
    else $error("handoff reported with failing status");

  a_new_id_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_id != '0) |-> (status == ST_OK && !wake_valid))
    else $error("new id reported outside successful create");

  a_wake_path: assert property (@(posedge clk) disable iff (rst)
    (state == S_WAKE) |-> $past(state) == S_HEAD && kind_q == K_UNLOCK)
    else $error("wake read outside unlock");

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Testbench for the mutex table with FIFO wait queues: stimulus, prediction and checking.
`timescale 1ns / 100ps
module testbench;
  import mtxq_pkg::*;

  // One result transaction as the block should present it
  typedef struct packed {
    status_t           st;
    logic [ID_W-1:0]   nid;
    logic              wv;
    logic [REQ_W-1:0]  wr;
  } reply_t;

  // Mirror of the mutex table. Predicts the reply to each accepted request and
  // holds the replies still owed by the block, oldest first.
  class lock_ledger;
    int               ids_issued;
    bit               active [MUTEXES];
    bit               locked [MUTEXES];
    logic [REQ_W-1:0] waiters [MUTEXES][WAITERS];
    int               head [MUTEXES];
    int               fill [MUTEXES];
    reply_t           replies_due [$];
    int               fails;

    function new();
      ids_issued = 0;
      fails      = 0;
      foreach (active[i]) begin
        active[i] = 1'b0;
        locked[i] = 1'b0;
        head[i]   = 0;
        fill[i]   = 0;
      end
    endfunction

    // Queue head = lock owner; only valid while fill > 0
    function logic [REQ_W-1:0] owner(int id);
      return waiters[id][head[id]];
    endfunction

    function void note_request(kind_t k, logic [ID_W-1:0] id, logic [REQ_W-1:0] who);
      reply_t r;
      r = '{ST_OK, '0, 1'b0, '0};
      if (k == K_CREATE) begin
        if (ids_issued >= MUTEXES) begin
          r.st = ST_NOSPACE;
        end else begin
          active[ids_issued] = 1'b1;
          locked[ids_issued] = 1'b0;
          head[ids_issued]   = 0;
          fill[ids_issued]   = 0;
          r.nid = ID_W'(ids_issued);
          ids_issued++;
        end
      end else if (id >= ids_issued || !active[id]) begin
        r.st = ST_INVALID;
      end else if (k == K_DESTROY) begin
        if (locked[id]) r.st = ST_BUSY;
        else active[id] = 1'b0;
      end else if (k == K_LOCK) begin
        // lock flag is set even when the request is refused
        locked[id] = 1'b1;
        if (fill[id] > 0 && owner(id) == who) begin
          r.st = ST_HELD;
        end else if (fill[id] >= WAITERS) begin
          r.st = ST_NOSPACE;
        end else begin
          waiters[id][(head[id] + fill[id]) % WAITERS] = who;
          fill[id]++;
          r.st = (owner(id) != who) ? ST_SUSPEND : ST_OK;
        end
      end else begin
        if (!locked[id] || fill[id] == 0 || owner(id) != who) begin
          r.st = ST_NOLOCK;
        end else begin
          head[id] = (head[id] + 1) % WAITERS;
          fill[id]--;
          if (fill[id] > 0) begin
            r.wv = 1'b1;
            r.wr = owner(id);
          end else begin
            locked[id] = 1'b0;
          end
        end
      end
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic [ST_W-1:0] st, logic [ID_W-1:0] nid, logic wv,
                              logic [REQ_W-1:0] wr);
      reply_t want;
      if (replies_due.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("unexpected result: status=%0d new_id=%0d wake=%0b wake_req=%h",
                   st, nid, wv, wr);
        return;
      end
      want = replies_due.pop_front();
      if (st !== want.st || nid !== want.nid || wv !== want.wv || wr !== want.wr) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: expected status=%0d new_id=%0d wake=%0b wake_req=%h, got status=%0d new_id=%0d wake=%0b wake_req=%h",
                   want.st, want.nid, want.wv, want.wr, st, nid, wv, wr);
      end
    endfunction
  endclass

  localparam int POOL = 6;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  kind = '0;
  logic [ID_W-1:0]    mutex_id = '0;
  logic [REQ_W-1:0]   requester = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ST_W-1:0]    status;
  logic [ID_W-1:0]    new_id;
  logic               wake_valid;
  logic [REQ_W-1:0]   wake_requester;

  lock_ledger         ledger;
  logic [REQ_W-1:0]   pool [POOL];   // small requester set so locks collide
  int                 sent = 0;
  int                 taken = 0;
  bit                 send_calm = 1'b0;
  bit                 recv_calm = 1'b0;

  mutex_table_with_fifo_waiters i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .mutex_id       (mutex_id),
    .requester      (requester),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .new_id         (new_id),
    .wake_valid     (wake_valid),
    .wake_requester (wake_requester)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive one request transaction. Valid drops only when a gap is drawn, so a
  // back-to-back request never sees valid lowered and raised in one step.
  task automatic transfer(kind_t k, logic [ID_W-1:0] id, logic [REQ_W-1:0] who);
    int gap;
    if (sent % 50 == 0) send_calm = ($urandom_range(0, 3) == 0);
    gap = send_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    mutex_id  <= id;
    requester <= who;
    // accepted at the first edge that samples stall low
    do @(posedge clk); while (in_stall !== 1'b0);
    ledger.note_request(k, id, who);
    sent++;
  endtask

  // Mostly well-formed traffic on live mutexes, some noise on any field.
  task automatic random_request();
    int               roll;
    int               id;
    int               live;
    kind_t            k;
    logic [REQ_W-1:0] who;
    roll = $urandom_range(0, 99);
    id   = (ledger.ids_issued > 0) ? $urandom_range(0, ledger.ids_issued - 1) : 0;
    who  = pool[$urandom_range(0, POOL - 1)];
    k    = K_LOCK;
    if (roll < 10) begin
      k   = kind_t'($urandom_range(0, 3));
      id  = $urandom_range(0, MUTEXES - 1);
      who = REQ_W'($urandom);
    end else if (roll < 18) begin
      k  = K_CREATE;
      id = $urandom_range(0, MUTEXES - 1);
    end else if (roll < 21) begin
      k  = K_DESTROY;
      id = $urandom_range(0, MUTEXES - 1);
    end else if (roll >= 60) begin
      k = K_UNLOCK;
      // owner releases most of the time, so queues drain and wrap
      if (ledger.fill[id] > 0 && $urandom_range(0, 3) != 0) who = ledger.owner(id);
    end
    // ids are never reused: keep a few mutexes alive for the rest of the run
    if (k == K_DESTROY && id < ledger.ids_issued && ledger.active[id] && !ledger.locked[id]) begin
      live = 0;
      foreach (ledger.active[i]) live += ledger.active[i];
      if (live <= 4) k = K_LOCK;
    end
    transfer(k, ID_W'(id), who);
  endtask

  // Result side: random stall before each result, with calm stretches.
  initial begin
    int hold;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (taken % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      hold = recv_calm ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      ledger.check_reply(status, new_id, wake_valid, wake_requester);
      taken++;
    end
  end

  initial begin
    ledger  = new();
    pool[0] = '0;
    pool[1] = '1;
    for (int p = 2; p < POOL; p++) pool[p] = REQ_W'($urandom);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: ids 0..2
    transfer(K_CREATE, 4'd0, 16'h0000);
    transfer(K_CREATE, 4'hF, 16'hFFFF);
    transfer(K_CREATE, 4'd7, 16'h8001);
    // mutex 0: take, retake by owner, waiter, foreign unlock, handoff, destroy while held
    transfer(K_LOCK,    4'd0, 16'hA5A5);
    transfer(K_LOCK,    4'd0, 16'hA5A5);
    transfer(K_LOCK,    4'd0, 16'h5A5A);
    transfer(K_UNLOCK,  4'd0, 16'h5A5A);
    transfer(K_UNLOCK,  4'd0, 16'hA5A5);
    transfer(K_DESTROY, 4'd0, 16'h0000);
    // mutex 1: unlock while free, destroy, then use after destroy; never-created id
    transfer(K_UNLOCK,  4'd1, 16'h0001);
    transfer(K_DESTROY, 4'd1, 16'h0001);
    transfer(K_LOCK,    4'd1, 16'h0001);
    transfer(K_LOCK,    4'hF, 16'hFFFF);
    // mutex 2: same waiter queued repeatedly until the queue is full
    transfer(K_LOCK, 4'd2, 16'h0000);
    repeat (WAITERS - 1) transfer(K_LOCK, 4'd2, 16'hFFFF);
    transfer(K_LOCK, 4'd2, 16'h1234);
    transfer(K_LOCK, 4'd2, 16'h0000);

    for (int n = 0; n < 900; n++) begin
      // drain the block completely once mid-run
      if (n == 450) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.replies_due.size() != 0);
      end
      random_request();
    end
    in_valid <= 1'b0;

    while (ledger.replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (ledger.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
